// File: design/ptts_pkg.sv
// shared types and constants for the periodic task tick scheduler
// no dependencies; used by ptts_slot_table and periodic_task_tick_scheduler
package ptts_pkg;

  // command codes of an input request
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_DISPATCH = 2'd1;
  localparam logic [1:0] CMD_ADD      = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DUE  = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // add answer status
  localparam logic ADD_STORED = 1'b0;
  localparam logic ADD_FULL   = 1'b1;

  // saturation point of the pending tick count
  localparam logic [2:0] PEND_MAX = 3'd7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] task_period;
    logic [15:0] first_delay;
  } in_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] task_index;
    logic       add_status;
    logic [2:0] ticks_done;
    logic       tick_lost;
    logic       last;
  } out_res_t;

  // write command into the slot table
  typedef struct packed {
    logic        we_delay;
    logic        we_period;
    logic [15:0] delay;
    logic [15:0] period;
  } slot_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_WALK,
    ST_DONE,
    ST_ADD
  } st_t;

endpackage

// File: design/ptts_slot_table.sv
// delay and period storage of the task slots, one address shared by write and read
// depends on ptts_pkg (slot_wr_t)
module ptts_slot_table #(
  parameter int NUM_SLOTS = 8,
  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic              clk,
  input  logic [IdxW-1:0]   addr,
  input  ptts_pkg::slot_wr_t wr,
  output logic [15:0]       rd_delay,
  output logic [15:0]       rd_period
);

  logic [15:0] delay_left   [NUM_SLOTS];
  logic [15:0] period_ticks [NUM_SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.we_delay) begin
      delay_left[addr] <= wr.delay;
    end
    if (wr.we_period) begin
      period_ticks[addr] <= wr.period;
    end
  end

  // read at the walk address
  assign rd_delay  = delay_left[addr];
  assign rd_period = period_ticks[addr];

endmodule

// File: design/periodic_task_tick_scheduler.sv
// periodic task tick scheduler: sequencer, pending tick count and result register
// depends on ptts_pkg and ptts_slot_table
//
// Usage: requests enter on in_valid/in_ready/in_data, results leave on
// out_valid/out_ready/out_data. cfg_wr_en with cfg_wr_data sets the running
// bit; write it only while no request is in progress.
// A tick request gives no result; ticks are counted only while running
// and the count saturates at 7, setting the lost flag.
// An add request scans the slots one per cycle for the lowest free one and
// answers with its index, or with a full status when no slot is free.
// A dispatch request walks the slots through the single decrement-and-compare
// unit once per pending tick, one slot a cycle unless a due result stalls on
// the output register, then a done result closes it.
// in_ready is high only while the sequencer is idle, one request at a time.
// Results sit in one output register; while the receiver stalls, the walk
// holds on the slot whose result cannot be written, and resumes on out_ready.
// Reset clears the running bit, the pending count, the lost flag, the slot
// used bits and the output valid bit; slot delays and periods are not cleared.
module periodic_task_tick_scheduler #(
  parameter int NUM_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptts_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ptts_pkg::out_res_t out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(NUM_SLOTS - 1);

  ptts_pkg::st_t      state, state_next;
  logic               running;
  logic [2:0]         pending;
  logic               lost_flag;
  logic [2:0]         handled;
  logic [NUM_SLOTS-1:0] slot_used;
  logic [IdxW-1:0]    idx;
  logic [15:0]        add_period;
  logic [15:0]        add_delay;

  logic               in_fire;
  logic               out_free;
  logic [15:0]        rd_delay;
  logic [15:0]        rd_period;
  logic [15:0]        dec_delay;
  logic               dec_zero;
  logic               cur_used;
  logic               at_last;
  logic [31:0]        idx_ext;

  // control decode
  logic               load_out;
  ptts_pkg::out_res_t out_next;
  ptts_pkg::slot_wr_t tbl_wr;
  logic               set_used;
  logic               idx_inc;
  logic               pend_dec;
  logic               lost_clr;

  assign in_ready = (state == ptts_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cur_used = slot_used[idx];
  assign at_last  = (idx == IdxLast);
  assign idx_ext  = 32'(idx);

  // shared decrement and zero compare
  assign dec_delay = rd_delay - 16'd1;
  assign dec_zero  = (dec_delay == 16'd0);

  ptts_slot_table #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_table (
    .clk       (clk),
    .addr      (idx),
    .wr        (tbl_wr),
    .rd_delay  (rd_delay),
    .rd_period (rd_period)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ptts_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.cmd)
            ptts_pkg::CMD_DISPATCH: state_next = ptts_pkg::ST_TICK;
            ptts_pkg::CMD_ADD:      state_next = ptts_pkg::ST_ADD;
            default:                state_next = ptts_pkg::ST_IDLE;
          endcase
        end
      end
      ptts_pkg::ST_TICK: begin
        state_next = (pending != 3'd0) ? ptts_pkg::ST_WALK : ptts_pkg::ST_DONE;
      end
      ptts_pkg::ST_WALK: begin
        if ((!(cur_used && dec_zero) || out_free) && at_last) begin
          state_next = ptts_pkg::ST_TICK;
        end
      end
      ptts_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = ptts_pkg::ST_IDLE;
        end
      end
      ptts_pkg::ST_ADD: begin
        if ((!cur_used || at_last) && out_free) begin
          state_next = ptts_pkg::ST_IDLE;
        end
      end
      default: state_next = ptts_pkg::ST_IDLE;
    endcase
  end

  // per-state actions
  always_comb begin
    load_out  = 1'b0;
    out_next  = '0;
    tbl_wr    = '0;
    set_used  = 1'b0;
    idx_inc   = 1'b0;
    pend_dec  = 1'b0;
    lost_clr  = 1'b0;
    case (state)
      ptts_pkg::ST_TICK: begin
        pend_dec = (pending != 3'd0);
      end
      ptts_pkg::ST_WALK: begin
        if (!cur_used) begin
          idx_inc = 1'b1;
        end else if (!dec_zero) begin
          idx_inc        = 1'b1;
          tbl_wr.we_delay = 1'b1;
          tbl_wr.delay   = dec_delay;
        end else if (out_free) begin
          idx_inc             = 1'b1;
          tbl_wr.we_delay     = 1'b1;
          tbl_wr.delay        = rd_period;
          load_out            = 1'b1;
          out_next.kind       = ptts_pkg::KIND_DUE;
          out_next.task_index = idx_ext[2:0];
        end
      end
      ptts_pkg::ST_DONE: begin
        if (out_free) begin
          load_out            = 1'b1;
          lost_clr            = 1'b1;
          out_next.kind       = ptts_pkg::KIND_DONE;
          out_next.ticks_done = handled;
          out_next.tick_lost  = lost_flag;
          out_next.last       = 1'b1;
        end
      end
      ptts_pkg::ST_ADD: begin
        if (!cur_used) begin
          if (out_free) begin
            set_used             = 1'b1;
            tbl_wr.we_delay      = 1'b1;
            tbl_wr.we_period     = 1'b1;
            tbl_wr.delay         = add_delay;
            tbl_wr.period        = add_period;
            load_out             = 1'b1;
            out_next.kind        = ptts_pkg::KIND_ADD;
            out_next.task_index  = idx_ext[2:0];
            out_next.add_status  = ptts_pkg::ADD_STORED;
            out_next.last        = 1'b1;
          end
        end else if (at_last) begin
          if (out_free) begin
            load_out            = 1'b1;
            out_next.kind       = ptts_pkg::KIND_ADD;
            out_next.add_status = ptts_pkg::ADD_FULL;
            out_next.last       = 1'b1;
          end
        end else begin
          idx_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptts_pkg::ST_IDLE;
      running   <= 1'b0;
      pending   <= 3'd0;
      lost_flag <= 1'b0;
      handled   <= 3'd0;
      slot_used <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        running <= cfg_wr_data;
      end
      // tick counting and dispatch bookkeeping
      if (in_fire && in_data.cmd == ptts_pkg::CMD_TICK && running) begin
        if (pending == ptts_pkg::PEND_MAX) begin
          lost_flag <= 1'b1;
        end else begin
          pending <= pending + 3'd1;
        end
      end
      if (in_fire && in_data.cmd == ptts_pkg::CMD_DISPATCH) begin
        handled <= 3'd0;
      end
      if (pend_dec) begin
        pending <= pending - 3'd1;
        handled <= handled + 3'd1;
      end
      if (lost_clr) begin
        lost_flag <= 1'b0;
      end
      if (set_used) begin
        slot_used[idx] <= 1'b1;
      end
      // slot walk pointer
      if (state == ptts_pkg::ST_IDLE || state == ptts_pkg::ST_TICK) begin
        idx <= '0;
      end else if (idx_inc) begin
        idx <= idx + IdxW'(1);
      end
      // output register
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      add_period <= in_data.task_period;
      add_delay  <= in_data.first_delay;
    end
    if (load_out) begin
      out_data <= out_next;
    end
  end

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !load_out)
    else $error("result register overwritten while stalled");

  // a due result never closes a request
  a_due_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == ptts_pkg::KIND_DUE |-> !out_data.last)
    else $error("due result marked last");

  // the walk only runs with at least one tick taken
  a_walk_handled: assert property (@(posedge clk) disable iff (rst)
    state == ptts_pkg::ST_WALK |-> handled != 3'd0)
    else $error("slot walk without a handled tick");

  // an add only claims a free slot
  a_add_free: assert property (@(posedge clk) disable iff (rst)
    set_used |-> !slot_used[idx])
    else $error("add wrote a used slot");

  // the done result clears the lost flag
  a_lost_cleared: assert property (@(posedge clk) disable iff (rst)
    lost_clr |=> !lost_flag)
    else $error("lost flag not cleared after done result");

endmodule
